// ===== design/fdtw_pkg.sv =====
// Package: shared types, constants and helpers of the fault-domain tree walker.
package fdtw_pkg;

  localparam int WORD_BITS = 32;
  localparam int CFG_IDX_BITS = 1;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
  typedef logic [2:0] wcnt_t;
  typedef logic [1:0] nres_t;

  localparam cfg_idx_t CFG_FAULT_MASK = 1'b0;
  localparam cfg_idx_t CFG_PERF_MASK  = 1'b1;

  localparam word_t FAULT_MASK_RST = word_t'(1);
  localparam word_t PERF_MASK_RST  = word_t'(2);

  localparam wcnt_t MIN_WORDS  = 3'd4;
  localparam word_t NODE_LEVEL = word_t'(1);
  localparam word_t ROOT_IDENT = word_t'(1);
  localparam word_t WORD_MAX   = '1;

  typedef enum logic [3:0] {
    KIND_ROOT       = 4'd0,
    KIND_NODE       = 4'd1,
    KIND_FAULT      = 4'd2,
    KIND_PERF       = 4'd3,
    KIND_RANK       = 4'd4,
    KIND_TRUNCATED  = 4'd5,
    KIND_UNKNOWN    = 4'd6,
    KIND_TOO_SHORT  = 4'd7,
    KIND_BEYOND_END = 4'd8
  } kind_t;

  typedef enum logic [1:0] {
    PH_LEVEL = 2'd0,
    PH_IDENT = 2'd1,
    PH_COUNT = 2'd2
  } phase_t;

  typedef struct packed {
    kind_t kind;
    word_t level;
    word_t ident;
    word_t value;
    logic  run_end;
  } result_t;

  typedef struct packed {
    wcnt_t  words_seen;
    phase_t tuple_phase;
    word_t  held_level;
    word_t  held_ident;
    logic   has_fault;
    logic   has_perf;
    word_t  domains_expected;
    word_t  domains_found;
    word_t  ranks_expected;
    word_t  ranks_found;
    word_t  fault_level;
    logic   fault_level_known;
    word_t  perf_level;
    logic   perf_level_known;
    logic   halted;
  } walk_state_t;

  // what one word produces: up to two results
  typedef struct packed {
    result_t r0;
    result_t r1;
    nres_t   n;
  } step_out_t;

  function automatic walk_state_t state_clear();
    walk_state_t s;
    s = '0;
    s.tuple_phase = PH_LEVEL;
    s.domains_expected = word_t'(1);
    return s;
  endfunction

  function automatic word_t sat_add(word_t a, word_t b);
    logic [WORD_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WORD_BITS] ? WORD_MAX : s[WORD_BITS-1:0];
  endfunction

  function automatic result_t make_result(kind_t k, word_t lvl, word_t id, word_t val);
    result_t r;
    r.kind = k;
    r.level = lvl;
    r.ident = id;
    r.value = val;
    r.run_end = 1'b0;
    return r;
  endfunction

endpackage

// ===== design/fdtw_ifs.sv =====
// Interfaces: input word channel and result channel of the tree walker.
interface fdtw_in_if;
  import fdtw_pkg::*;
  logic  valid;
  logic  ready;
  word_t word;
  logic  last_word;
  modport source (output valid, output word, output last_word, input ready);
  modport sink (input valid, input word, input last_word, output ready);
endinterface

interface fdtw_out_if;
  import fdtw_pkg::*;
  logic  valid;
  logic  ready;
  kind_t kind;
  word_t level;
  word_t ident;
  word_t value;
  logic  run_end;
  modport source (output valid, output kind, output level, output ident,
                  output value, output run_end, input ready);
  modport sink (input valid, input kind, input level, input ident,
                input value, input run_end, output ready);
endinterface

// ===== design/fdtw_step.sv =====
// Step logic: next walk state and the results caused by one input word.
module fdtw_step (
  input  fdtw_pkg::walk_state_t st,
  input  fdtw_pkg::word_t       word,
  input  logic                  last_word,
  input  fdtw_pkg::word_t       fault_mask,
  input  fdtw_pkg::word_t       perf_mask,
  output fdtw_pkg::walk_state_t st_nxt,
  output fdtw_pkg::step_out_t   res
);
  import fdtw_pkg::*;

  walk_state_t s;
  step_out_t   o;
  logic        dom_done;
  logic        rank_done;
  logic        need_perf;
  logic        need_fault;
  logic        all_done;
  kind_t       tkind;
  logic        tknown;
  wcnt_t       ws_inc;

  assign dom_done   = st.domains_found >= st.domains_expected;
  assign rank_done  = st.ranks_found >= st.ranks_expected;
  assign need_perf  = st.has_perf && !st.perf_level_known;
  assign need_fault = st.has_fault && !st.fault_level_known;
  assign ws_inc     = (st.words_seen < MIN_WORDS) ? st.words_seen + 3'd1 : st.words_seen;

  // classify the held triple
  always_comb begin
    tknown = 1'b1;
    tkind  = KIND_UNKNOWN;
    priority if (st.held_ident == ROOT_IDENT) begin
      tkind = KIND_ROOT;
    end else if (st.held_level == NODE_LEVEL) begin
      tkind = KIND_NODE;
    end else if (!need_perf && (need_fault ||
                 (st.fault_level_known && st.fault_level == st.held_level))) begin
      tkind = KIND_FAULT;
    end else if (need_perf || (st.perf_level_known && st.perf_level == st.held_level)) begin
      tkind = KIND_PERF;
    end else begin
      tknown = 1'b0;
    end
  end

  always_comb begin
    s   = st;
    o   = '0;
    all_done = 1'b0;
    if (st.words_seen == '0) begin
      s.has_fault  = |(word & fault_mask);
      s.has_perf   = |(word & perf_mask);
      s.words_seen = 3'd1;
    end else begin
      if (!st.halted) begin
        priority if (dom_done && rank_done) begin
          s.halted = 1'b1;
          o.r0 = make_result(KIND_BEYOND_END, '0, '0, '0);
          o.n  = 2'd1;
        end else if (!dom_done) begin
          unique case (st.tuple_phase)
            PH_LEVEL: begin
              s.held_level  = word;
              s.tuple_phase = PH_IDENT;
            end
            PH_IDENT: begin
              s.held_ident  = word;
              s.tuple_phase = PH_COUNT;
            end
            default: begin
              s.tuple_phase = PH_LEVEL;
              o.n = 2'd1;
              if (!tknown) begin
                s.halted = 1'b1;
                o.r0 = make_result(KIND_UNKNOWN, '0, '0, '0);
              end else begin
                o.r0 = make_result(tkind, st.held_level, st.held_ident, word);
                s.domains_found = sat_add(st.domains_found, word_t'(1));
                // children at the node level are ranks, even under a root
                if (st.held_level == NODE_LEVEL) begin
                  s.ranks_expected = sat_add(st.ranks_expected, word);
                end else begin
                  s.domains_expected = sat_add(st.domains_expected, word);
                end
                if (tkind == KIND_FAULT && need_fault) begin
                  s.fault_level       = st.held_level;
                  s.fault_level_known = 1'b1;
                end
                if (tkind == KIND_PERF && need_perf) begin
                  s.perf_level       = st.held_level;
                  s.perf_level_known = 1'b1;
                end
              end
            end
          endcase
        end else begin
          s.ranks_found = sat_add(st.ranks_found, word_t'(1));
          o.r0 = make_result(KIND_RANK, '0, '0, word);
          o.n  = 2'd1;
        end
      end
      s.words_seen = ws_inc;
    end

    if (last_word) begin
      all_done = s.domains_found >= s.domains_expected &&
                 s.ranks_found >= s.ranks_expected && s.tuple_phase == PH_LEVEL;
      if (s.words_seen < MIN_WORDS) begin
        o.r0 = make_result(KIND_TOO_SHORT, '0, '0, '0);
        o.n  = 2'd1;
      end else if (!s.halted && !all_done) begin
        if (o.n == 2'd0) begin
          o.r0 = make_result(KIND_TRUNCATED, '0, '0, '0);
        end else begin
          o.r1 = make_result(KIND_TRUNCATED, '0, '0, '0);
        end
        o.n = o.n + 2'd1;
      end
      s = state_clear();
    end

    if (o.n == 2'd1) o.r0.run_end = 1'b1;
    if (o.n == 2'd2) o.r1.run_end = 1'b1;
  end

  assign st_nxt = s;
  assign res    = o;

endmodule

// ===== design/fdtw_outq.sv =====
// Result queue: four entries, takes up to two results and gives one per cycle.
module fdtw_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  fdtw_pkg::step_out_t push,
  input  logic                pop,
  output fdtw_pkg::result_t   head,
  output fdtw_pkg::wcnt_t     count
);
  import fdtw_pkg::*;

  result_t     mem_r [4];
  logic [1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [1:0]  rd_ptr_r, rd_ptr_nxt;
  wcnt_t       cnt_r, cnt_nxt;

  assign wr_ptr_nxt = wr_ptr_r + push.n;
  assign rd_ptr_nxt = rd_ptr_r + {1'b0, pop};
  assign cnt_nxt    = cnt_r + {1'b0, push.n} - {2'b00, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem_r[wr_ptr_r] <= push.r0;
    if (push.n == 2'd2) mem_r[wr_ptr_r + 2'd1] <= push.r1;
  end

  assign head  = mem_r[rd_ptr_r];
  assign count = cnt_r;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4) else $error("result queue count over depth");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 3'd0 || cnt_r == 3'd4) |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers disagree with count");
`endif

endmodule

// ===== design/fault_domain_tree_walker.sv =====
// Top level: fault-domain tree walker, one array word in, zero to two results out.
//
//  channel  | dir | beat payload                         | accept
//  in_ch    | in  | word, last_word                      | valid && ready
//  out_ch   | out | kind, level, ident, value, run_end   | valid && ready
//  cfg_*    | in  | cfg_idx, cfg_wdata                   | cfg_we
//
// One word is taken per cycle while in_ch.ready is high; its results enter a
// four-entry queue the same edge. in_ch.ready is high while the queue holds at most
// two results, so a word giving one result sustains one beat per cycle while
// out_ch.ready is high; two-result words leave one result queued for out_ch.
// Synchronous reset clears the walk state, the queue and loads the default masks.
module fault_domain_tree_walker (
  input  logic               clk,
  input  logic               rst_n,
  fdtw_in_if.sink            in_ch,
  fdtw_out_if.source         out_ch,
  input  logic               cfg_we,
  input  fdtw_pkg::cfg_idx_t cfg_idx,
  input  fdtw_pkg::word_t    cfg_wdata
);
  import fdtw_pkg::*;

  walk_state_t st_r, st_nxt;
  word_t       fault_mask_r, perf_mask_r;
  step_out_t   step_res;
  step_out_t   push;
  result_t     head;
  wcnt_t       q_count;
  logic        in_acc;
  logic        out_acc;

  assign in_ch.ready = q_count <= 3'd2;
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  fdtw_step u_step (
    .st         (st_r),
    .word       (in_ch.word),
    .last_word  (in_ch.last_word),
    .fault_mask (fault_mask_r),
    .perf_mask  (perf_mask_r),
    .st_nxt     (st_nxt),
    .res        (step_res)
  );

  always_comb begin
    push = step_res;
    if (!in_acc) push.n = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= state_clear();
    end else if (in_acc) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fault_mask_r <= FAULT_MASK_RST;
      perf_mask_r  <= PERF_MASK_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_FAULT_MASK: fault_mask_r <= cfg_wdata;
        CFG_PERF_MASK:  perf_mask_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  fdtw_outq u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (out_acc),
    .head  (head),
    .count (q_count)
  );

  assign out_ch.valid   = q_count != 3'd0;
  assign out_ch.kind    = head.kind;
  assign out_ch.level   = head.level;
  assign out_ch.ident   = head.ident;
  assign out_ch.value   = head.value;
  assign out_ch.run_end = head.run_end;

`ifndef NO_ASSERTIONS
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.last_word) |=> st_r.words_seen == 3'd0)
    else $error("walk state not cleared after last word");
  a_halt_after_meta: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.halted |-> st_r.words_seen >= 3'd2)
    else $error("halted before any triple word");
  a_room_two: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> q_count >= {1'b0, $past(push.n)})
    else $error("accepted word results lost from queue");
  a_ws_sat: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.words_seen <= MIN_WORDS) else $error("word count past saturation");
`endif

endmodule
